/* rtl/core/pwlf_pkg.sv */
// ----------------------------------------------------------------------------
// pwlf_pkg
// Shared types and constants of the flow to drive lookup: item opcodes,
// register indexes, reset values and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package pwlf_pkg;

   // field widths
   localparam int DATA_W  = 16;
   localparam int INDEX_W = 7;
   localparam int CSR_IW  = 1;

   // item opcodes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // register indexes
   localparam logic [CSR_IW-1:0] REG_FLOW_STEP  = 1'b0;
   localparam logic [CSR_IW-1:0] REG_STEP_RECIP = 1'b1;

   // register reset values
   localparam logic [DATA_W-1:0] FLOW_STEP_RST  = 16'd9;
   localparam logic [DATA_W-1:0] STEP_RECIP_RST = 16'd7281;

   // commands from the controller to the datapath
   typedef struct packed {
      logic write;   // store one table word from the request
      logic load;    // capture the flow of a lookup
      logic mul1;    // flow times reciprocal
      logic clamp;   // limit the segment index
      logic read;    // read both breakpoints, form segment base
      logic mul2;    // delta times diff
      logic mul3;    // scale by the reciprocal
      logic finish;  // form the drive value and raise the strobe
   } ctl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic flow_zero;  // requested flow is zero
   } dp_status_type;

endpackage

/* rtl/core/pwlf_ctrl.sv */
// ----------------------------------------------------------------------------
// pwlf_ctrl
// Sequencer of the lookup: takes items from the command port and steps the
// datapath through multiply, clamp, table read, interpolation and output.
// ----------------------------------------------------------------------------
module pwlf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_op,
   input  pwlf_pkg::dp_status_type status,
   output logic                    busy,
   output pwlf_pkg::ctl_cmd_type   cmd
);
   import pwlf_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MUL1   = 3'd1;
   localparam logic [2:0] S_CLAMP  = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_MUL2   = 3'd4;
   localparam logic [2:0] S_MUL3   = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_op == OP_LOOKUP) begin
               state_in = status.flow_zero ? S_FINISH : S_MUL1;
            end
         end
         S_MUL1:   state_in = S_CLAMP;
         S_CLAMP:  state_in = S_READ;
         S_READ:   state_in = S_MUL2;
         S_MUL2:   state_in = S_MUL3;
         S_MUL3:   state_in = S_FINISH;
         S_FINISH: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands
   always_comb begin
      cmd        = '0;
      cmd.write  = accept && (req_op == OP_WRITE);
      cmd.load   = accept && (req_op == OP_LOOKUP);
      cmd.mul1   = (state_ff == S_MUL1);
      cmd.clamp  = (state_ff == S_CLAMP);
      cmd.read   = (state_ff == S_READ);
      cmd.mul2   = (state_ff == S_MUL2);
      cmd.mul3   = (state_ff == S_MUL3);
      cmd.finish = (state_ff == S_FINISH);
   end

endmodule

/* rtl/core/pwlf_datapath.sv */
// ----------------------------------------------------------------------------
// pwlf_datapath
// Drive table, step registers and the interpolation arithmetic, one
// multiplier stage per step, with the registered result strobe.
// ----------------------------------------------------------------------------
module pwlf_datapath #(
   parameter int TABLE_ENTRIES = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pwlf_pkg::ctl_cmd_type           cmd,
   output pwlf_pkg::dp_status_type         status,
   input  logic [pwlf_pkg::INDEX_W-1:0]    req_entry_index,
   input  logic [pwlf_pkg::DATA_W-1:0]     req_entry_value,
   input  logic [pwlf_pkg::DATA_W-1:0]     req_flow,
   input  logic                            csr_we,
   input  logic [pwlf_pkg::CSR_IW-1:0]     csr_index,
   input  logic [pwlf_pkg::DATA_W-1:0]     csr_wdata,
   output logic                            rsp_strobe,
   output logic [pwlf_pkg::DATA_W-1:0]     rsp_drive
);
   import pwlf_pkg::*;

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int PW = IW + DATA_W;
   localparam logic [DATA_W-1:0] SEG_MAX = DATA_W'(TABLE_ENTRIES - 2);

   logic [DATA_W-1:0]   mem [TABLE_ENTRIES];
   logic [DATA_W-1:0]   flow_step_ff;
   logic [DATA_W-1:0]   step_recip_ff;
   logic [DATA_W-1:0]   flow_ff;
   logic [DATA_W-1:0]   seg_raw_ff;
   logic [IW-1:0]       seg_ff;
   logic [IW-1:0]       seg_next;
   logic [DATA_W-1:0]   base_ff;
   logic [DATA_W-1:0]   bot_ff;
   logic [DATA_W-1:0]   top_ff;
   logic [31:0]         prod2_ff;
   logic [31:0]         prod3_ff;
   logic [DATA_W-1:0]   drive_ff;
   logic                strobe_ff;
   logic [31:0]         mul1;
   logic [PW-1:0]       seg_base;
   logic [DATA_W-1:0]   delta;
   logic [DATA_W-1:0]   diff;
   logic                wr_in_range;

   assign status.flow_zero = (req_flow == '0);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         flow_step_ff  <= FLOW_STEP_RST;
         step_recip_ff <= STEP_RECIP_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_FLOW_STEP:  flow_step_ff  <= csr_wdata;
            REG_STEP_RECIP: step_recip_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // table write, indexes past the table are dropped
   assign wr_in_range = (32'(req_entry_index) < 32'(TABLE_ENTRIES));

   always_ff @(posedge clock) begin
      if (cmd.write && wr_in_range) begin
         mem[IW'(req_entry_index)] <= req_entry_value;
      end
   end

   // breakpoint reads at the segment and the one above it
   assign seg_next = seg_ff + IW'(1);

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         bot_ff <= mem[seg_ff];
         top_ff <= mem[seg_next];
      end
   end

   // segment index from the reciprocal
   assign mul1     = 32'(flow_ff) * 32'(step_recip_ff);
   assign seg_base = PW'(seg_ff) * PW'(flow_step_ff);
   assign delta    = flow_ff - base_ff;
   assign diff     = top_ff - bot_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         flow_ff <= req_flow;
      end
      if (cmd.mul1) begin
         seg_raw_ff <= mul1[31:16];
      end
      if (cmd.clamp) begin
         seg_ff <= (seg_raw_ff > SEG_MAX) ? IW'(SEG_MAX) : IW'(seg_raw_ff);
      end
      if (cmd.read) begin
         base_ff <= seg_base[DATA_W-1:0];
      end
      // interpolation, each product wraps to 32 bits
      if (cmd.mul2) begin
         prod2_ff <= 32'(delta) * 32'(diff);
      end
      if (cmd.mul3) begin
         prod3_ff <= prod2_ff * 32'(step_recip_ff);
      end
      if (cmd.finish) begin
         drive_ff <= (flow_ff == '0) ? '0 : (bot_ff + prod3_ff[31:16]);
      end
   end

   // result strobe, one cycle per lookup
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.finish;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_drive  = drive_ff;

endmodule

/* rtl/core/pwl_flow_to_pwm_lookup.sv */
// ----------------------------------------------------------------------------
// pwl_flow_to_pwm_lookup
// Piecewise-linear flow to valve drive lookup over a table of breakpoints.
// ----------------------------------------------------------------------------
// A write item (req_op 0) stores one table word and is done in the cycle it
// is taken; busy stays low. A lookup item (req_op 1) keeps busy high while
// the sequencer runs; its drive value appears on rsp_drive with rsp_strobe
// high for one cycle right after busy falls. The sequencer walks a lookup one
// multiplier stage at a time: segment multiply, clamp, registered table read
// of both breakpoints, delta times diff, reciprocal scale, output; a flow of
// zero goes straight to the output step. The receiver cannot hold a result
// off, so a result must be taken in its strobe cycle; a new item may be
// started in that same cycle. Table entries read by a lookup must have been
// written since reset. Write the step registers only while busy is low.
// ----------------------------------------------------------------------------
module pwl_flow_to_pwm_lookup #(
   parameter int TABLE_ENTRIES = 128
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_op,
   input  logic [pwlf_pkg::INDEX_W-1:0] req_entry_index,
   input  logic [pwlf_pkg::DATA_W-1:0]  req_entry_value,
   input  logic [pwlf_pkg::DATA_W-1:0]  req_flow,
   output logic                         rsp_strobe,
   output logic [pwlf_pkg::DATA_W-1:0]  rsp_drive,
   input  logic                         csr_we,
   input  logic [pwlf_pkg::CSR_IW-1:0]  csr_index,
   input  logic [pwlf_pkg::DATA_W-1:0]  csr_wdata
);
   import pwlf_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   // sequencer
   pwlf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // table and arithmetic
   pwlf_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_flow        (req_flow),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_strobe      (rsp_strobe),
      .rsp_drive       (rsp_drive)
   );

`ifndef ASSERT_OFF
   // a lookup transfer keeps the sequencer busy in the next cycle
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == OP_LOOKUP) |=> busy)
      else $error("lookup taken without going busy");

   // a result is only shown once the sequencer has gone idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // zero flow gives a zero drive with the strobe once the finish state has passed
   a_zero_flow: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == OP_LOOKUP && req_flow == '0)
         |=> ##1 (rsp_strobe && rsp_drive == '0))
      else $error("zero flow did not give zero drive");
`endif

endmodule
